// ===== hw/rtl/fgpid_pkg.sv =====
// shared types, constants and the control program of the fuzzy-gain pid controller
`default_nettype none

package fgpid_pkg;

  // fixed number formats
  localparam int DATA_W      = 16;               // q4.12 samples, gains and rule entries
  localparam int FRAC_BITS   = 12;
  localparam int WEIGHT_W    = FRAC_BITS + 1;    // interpolation weight, 0 .. 1.0
  localparam int WPROD_W     = 2 * WEIGHT_W - 1; // corner weight product, 0 .. 1.0 in q.24
  localparam int MUL_A_W     = WPROD_W + 1;
  localparam int MUL_B_W     = DATA_W + 1;
  localparam int ACC_W       = 42;
  localparam int OUT_W       = 32;               // q20.12 drive and increment
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;
  localparam int PC_W        = 5;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_BITS);

  // operation codes carried in tuser
  localparam logic OPC_SAMPLE = 1'b0;
  localparam logic OPC_LOAD   = 1'b1;

  // rule table selectors
  localparam logic [1:0] TBL_KP = 2'd0;
  localparam logic [1:0] TBL_KI = 2'd1;
  localparam logic [1:0] TBL_KD = 2'd2;
  localparam int         TBL_COUNT = 3;

  // configuration register indexes
  localparam logic [1:0] REG_BASE_KP = 2'd0;
  localparam logic [1:0] REG_BASE_KI = 2'd1;
  localparam logic [1:0] REG_BASE_KD = 2'd2;

  localparam logic signed [DATA_W-1:0] BASE_KP_RST = DATA_W'(205);
  localparam logic signed [DATA_W-1:0] BASE_KI_RST = DATA_W'(82);
  localparam logic signed [DATA_W-1:0] BASE_KD_RST = DATA_W'(90);

  typedef logic [PC_W-1:0] pc_t;

  // datapath operations, one per step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERR,    // e = sat(measured - target)
    OP_EC,     // ec = sat(e - prev), locate e
    OP_LOCC,   // locate ec
    OP_GAIN,   // gain[gsel] = sat(base + rounded correction)
    OP_GBASE,  // all gains = base gains
    OP_INC,    // rounded increment from accumulator
    OP_OUT     // update drive, history and the result register
  } op_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_WPROD, // corner weight product
    MUL_TERM,  // corner weight times rule entry
    MUL_GAIN   // gain times error history
  } mul_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } acc_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_WAIT_IN,  // hold until a sample is taken
    J_NOSPAN,   // branch when e or ec lies outside the rule span
    J_GOTO,
    J_OUT       // branch once the result register is free
  } jump_e;

  typedef struct packed {
    op_e        op;
    mul_e       mul;
    logic [1:0] msel;      // corner or gain index for the multiplier
    acc_e       acc;
    logic [1:0] gsel;      // gain written by OP_GAIN
    logic       rd;
    logic [1:0] rd_tbl;
    logic [1:0] rd_corner; // bit 0 next error cell, bit 1 next change cell
    jump_e      jmp;
    pc_t        target;
  } uword_t;

  localparam pc_t PC_IDLE       = pc_t'(0);
  localparam pc_t PC_GAIN_PRODS = pc_t'(22);
  localparam pc_t PC_NOSPAN     = pc_t'(28);

  localparam uword_t UW_NOP = '{
    op: OP_NONE, mul: MUL_NONE, msel: 2'd0, acc: ACC_NONE, gsel: 2'd0,
    rd: 1'b0, rd_tbl: 2'd0, rd_corner: 2'd0, jmp: J_NEXT, target: PC_IDLE
  };

  // control program
  function automatic uword_t ucode(input pc_t pc);
    uword_t uw;
    uw = UW_NOP;
    unique case (pc)
      pc_t'(0): begin
        uw.jmp = J_WAIT_IN;
      end
      pc_t'(1): uw.op = OP_ERR;
      pc_t'(2): uw.op = OP_EC;
      pc_t'(3): begin
        uw.op = OP_LOCC; uw.jmp = J_NOSPAN; uw.target = PC_NOSPAN;
      end
      pc_t'(4): begin uw.mul = MUL_WPROD; uw.msel = 2'd0; end
      pc_t'(5): begin uw.mul = MUL_WPROD; uw.msel = 2'd1; end
      pc_t'(6): begin uw.mul = MUL_WPROD; uw.msel = 2'd2; end
      pc_t'(7): begin
        uw.mul = MUL_WPROD; uw.msel = 2'd3;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KP; uw.rd_corner = 2'd0;
      end
      pc_t'(8): begin
        uw.mul = MUL_TERM; uw.msel = 2'd0;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KP; uw.rd_corner = 2'd1;
      end
      pc_t'(9): begin
        uw.mul = MUL_TERM; uw.msel = 2'd1; uw.acc = ACC_LOAD;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KP; uw.rd_corner = 2'd2;
      end
      pc_t'(10): begin
        uw.mul = MUL_TERM; uw.msel = 2'd2; uw.acc = ACC_ADD;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KP; uw.rd_corner = 2'd3;
      end
      pc_t'(11): begin
        uw.mul = MUL_TERM; uw.msel = 2'd3; uw.acc = ACC_ADD;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KI; uw.rd_corner = 2'd0;
      end
      pc_t'(12): begin
        uw.mul = MUL_TERM; uw.msel = 2'd0; uw.acc = ACC_ADD;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KI; uw.rd_corner = 2'd1;
      end
      pc_t'(13): begin
        uw.mul = MUL_TERM; uw.msel = 2'd1; uw.acc = ACC_LOAD;
        uw.op = OP_GAIN; uw.gsel = TBL_KP;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KI; uw.rd_corner = 2'd2;
      end
      pc_t'(14): begin
        uw.mul = MUL_TERM; uw.msel = 2'd2; uw.acc = ACC_ADD;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KI; uw.rd_corner = 2'd3;
      end
      pc_t'(15): begin
        uw.mul = MUL_TERM; uw.msel = 2'd3; uw.acc = ACC_ADD;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KD; uw.rd_corner = 2'd0;
      end
      pc_t'(16): begin
        uw.mul = MUL_TERM; uw.msel = 2'd0; uw.acc = ACC_ADD;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KD; uw.rd_corner = 2'd1;
      end
      pc_t'(17): begin
        uw.mul = MUL_TERM; uw.msel = 2'd1; uw.acc = ACC_LOAD;
        uw.op = OP_GAIN; uw.gsel = TBL_KI;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KD; uw.rd_corner = 2'd2;
      end
      pc_t'(18): begin
        uw.mul = MUL_TERM; uw.msel = 2'd2; uw.acc = ACC_ADD;
        uw.rd = 1'b1; uw.rd_tbl = TBL_KD; uw.rd_corner = 2'd3;
      end
      pc_t'(19): begin uw.mul = MUL_TERM; uw.msel = 2'd3; uw.acc = ACC_ADD; end
      pc_t'(20): uw.acc = ACC_ADD;
      pc_t'(21): begin uw.op = OP_GAIN; uw.gsel = TBL_KD; end
      pc_t'(22): begin uw.mul = MUL_GAIN; uw.msel = 2'd0; end
      pc_t'(23): begin uw.mul = MUL_GAIN; uw.msel = 2'd1; uw.acc = ACC_LOAD; end
      pc_t'(24): begin uw.mul = MUL_GAIN; uw.msel = 2'd2; uw.acc = ACC_ADD; end
      pc_t'(25): uw.acc = ACC_ADD;
      pc_t'(26): uw.op = OP_INC;
      pc_t'(27): begin
        uw.op = OP_OUT; uw.jmp = J_OUT; uw.target = PC_IDLE;
      end
      pc_t'(28): begin
        uw.op = OP_GBASE; uw.jmp = J_GOTO; uw.target = PC_GAIN_PRODS;
      end
      default: begin
        uw.jmp = J_GOTO; uw.target = PC_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fuzzy_gain_pid_controller.sv =====
// top level of the fuzzy self-tuning incremental pid controller
`default_nettype none

// Incremental PID controller whose three gains are tuned per sample from
// fuzzy rule tables. A sample item (tuser 0) forms e = measured - target and
// ec = e - previous e, both saturated Q4.12. If both lie in [-H, H]
// (H = (RULE_LEVELS-1)/2) the kp, ki and kd corrections are bilinearly
// interpolated from three RULE_LEVELS x RULE_LEVELS rule tables (rows by ec
// cell, columns by e cell) and added to the base gains; otherwise the base
// gains are used alone. The increment gain_p*e + gain_i*e[n-1] + gain_d*e[n-2]
// is rounded to Q20.12 and accumulated into the saturating drive; one result
// item {increment, drive} goes out per sample. A load item (tuser 1) writes one
// rule entry and gives no result; entries must be loaded before a sample
// reads them (the rule ram comes out of reset unwritten and needs no clearing
// pass). A sample is run by a 29-step microprogram over one shared 26x17
// multiplier and the single read port of the rule ram (twelve entry reads,
// four weight products, twelve corner terms, three gain products); no new
// item is taken until the sample has left its last step. An out-of-span
// sample skips the interpolation and uses the base gains.
// The result register frees the input side while a result waits; a sample
// finishing while the previous result is still unread holds at its last step.
// Base gains sit at byte addresses 0, 4 and 8 of the apb port and should only
// be written while the block is idle.

module fuzzy_gain_pid_controller
  import fgpid_pkg::*;
#(
  parameter int RULE_LEVELS = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input items
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // target [15:0], measured [31:16], table_select [33:32], rule_row [36:34],
  // rule_col [39:37], rule_value [55:40]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // operation [0]
  input  logic [0:0]             s_axis_tuser_i,
  // result items
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // drive [31:0], increment [63:32]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int HALF     = (RULE_LEVELS - 1) / 2;
  localparam int CELLS    = 2 * HALF;
  localparam int TBL_SIZE = RULE_LEVELS * RULE_LEVELS;
  localparam int DEPTH    = TBL_COUNT * TBL_SIZE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int IDX_W    = $clog2(RULE_LEVELS);
  localparam int K_W      = DATA_W + 1 - FRAC_BITS;
  localparam int CORR_W   = ACC_W - 2 * FRAC_BITS;
  localparam int GSUM_W   = CORR_W + 1;
  localparam int INC_W    = ACC_W - FRAC_BITS;

  localparam logic signed [DATA_W:0] SPAN_S     = (DATA_W + 1)'(HALF << FRAC_BITS);
  localparam logic signed [DATA_W:0] NEG_SPAN_S = -SPAN_S;
  localparam logic [K_W-1:0]         K_MAX      = K_W'(CELLS - 1);
  localparam logic signed [ACC_W-1:0] CORR_HALF = ACC_W'(1) <<< (2 * FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] INC_HALF  = ACC_W'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic                in_span;
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] wl;
    logic [WEIGHT_W-1:0] wr;
  } loc_t;

  // cell index and left/right weights of a q4.12 value
  function automatic loc_t locate(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W:0] vx;
    logic [DATA_W:0]        off;
    logic [K_W-1:0]         k;
    logic [WEIGHT_W-1:0]    frac;
    loc_t                   r;
    vx        = {v[DATA_W-1], v};
    r.in_span = (vx <= SPAN_S) && (vx >= NEG_SPAN_S);
    off       = unsigned'(vx + SPAN_S);
    k         = off[DATA_W:FRAC_BITS];
    frac      = {1'b0, off[FRAC_BITS-1:0]};
    // the top edge of the span belongs to the last cell
    if (k > K_MAX) begin
      k    = K_MAX;
      frac = WEIGHT_ONE;
    end
    r.idx = IDX_W'(k);
    r.wl  = WEIGHT_ONE - frac;
    r.wr  = frac;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input int tbl, input int row, input int col);
    return ADDR_W'(tbl * TBL_SIZE + row * RULE_LEVELS + col);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_dw(input logic signed [DATA_W:0] x);
    if (x[DATA_W] != x[DATA_W-1]) begin
      return {x[DATA_W], {(DATA_W - 1){~x[DATA_W]}}};
    end
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_gain(input logic signed [GSUM_W-1:0] x);
    if ((x[GSUM_W-1:DATA_W-1] != '0) && (x[GSUM_W-1:DATA_W-1] != '1)) begin
      return {x[GSUM_W-1], {(DATA_W - 1){~x[GSUM_W-1]}}};
    end
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [OUT_W:0] x);
    if (x[OUT_W] != x[OUT_W-1]) begin
      return {x[OUT_W], {(OUT_W - 1){~x[OUT_W]}}};
    end
    return x[OUT_W-1:0];
  endfunction

  // input fields
  logic                     in_op;
  logic signed [DATA_W-1:0] in_target;
  logic signed [DATA_W-1:0] in_measured;
  logic [1:0]               in_tsel;
  logic [2:0]               in_row;
  logic [2:0]               in_col;
  logic [DATA_W-1:0]        in_rule_value;

  assign in_op         = s_axis_tuser_i[0];
  assign in_target     = s_axis_tdata_i[15:0];
  assign in_measured   = s_axis_tdata_i[31:16];
  assign in_tsel       = s_axis_tdata_i[33:32];
  assign in_row        = s_axis_tdata_i[36:34];
  assign in_col        = s_axis_tdata_i[39:37];
  assign in_rule_value = s_axis_tdata_i[55:40];

  // sequencer
  pc_t    pc_q, pc_d;
  uword_t uw;

  logic in_acc, sample_acc, load_wr, span_ok, out_free, do_out;

  assign uw              = ucode(pc_q);
  assign s_axis_tready_o = (pc_q == PC_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign sample_acc      = in_acc && (in_op == OPC_SAMPLE);
  // out-of-range load addresses are dropped
  assign load_wr         = in_acc && (in_op == OPC_LOAD) && (int'(in_tsel) < TBL_COUNT)
                           && (int'(in_row) < RULE_LEVELS) && (int'(in_col) < RULE_LEVELS);

  // datapath state
  logic signed [DATA_W-1:0]  target_q, meas_q, e_q, ec_q;
  logic signed [DATA_W-1:0]  prev_q, pp_q;
  logic [IDX_W-1:0]          ie_q, ic_q;
  logic [WEIGHT_W-1:0]       el_q, er_q, cl_q, cr_q;
  logic                      espan_q;
  logic [WPROD_W-1:0]        w_q [4];
  logic signed [ACC_W-1:0]   prod_q, acc_q;
  logic signed [DATA_W-1:0]  gain_q [TBL_COUNT];
  logic signed [DATA_W-1:0]  base_q [TBL_COUNT];
  logic signed [OUT_W-1:0]   inc_q, out_inc_q, drive_q;
  logic                      out_valid_q;

  logic signed [DATA_W-1:0]  e_d, ec_d, prev_d, pp_d;
  logic [IDX_W-1:0]          ie_d, ic_d;
  logic [WEIGHT_W-1:0]       el_d, er_d, cl_d, cr_d;
  logic                      espan_d;
  logic signed [OUT_W-1:0]   inc_d, out_inc_d, drive_d;
  logic                      out_valid_d;

  loc_t                      loc_e, loc_c;
  logic signed [ACC_W-1:0]   corr_rnd, inc_rnd;
  logic signed [CORR_W-1:0]  corr;
  logic signed [GSUM_W-1:0]  gsum;
  logic signed [DATA_W-1:0]  gain_new;
  logic signed [INC_W-1:0]   inc_new;

  // rule ram
  logic [ADDR_W-1:0] ram_raddr, ram_waddr;
  logic [DATA_W-1:0] ram_rdata;

  assign ram_waddr = addr_of(int'(in_tsel), int'(in_row), int'(in_col));
  assign ram_raddr = addr_of(int'(uw.rd_tbl), int'(ic_q) + int'(uw.rd_corner[1]),
                             int'(ie_q) + int'(uw.rd_corner[0]));

  fgpid_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_rules (
    .clk_i  (clk_i),
    .we_i   (load_wr),
    .waddr_i(ram_waddr),
    .wdata_i(in_rule_value),
    .re_i   (uw.rd),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // shared multiplier
  logic signed [MUL_A_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]         mul_b;
  logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
  logic signed [DATA_W-1:0]          hist_sel;

  always_comb begin
    hist_sel = e_q;
    case (uw.msel)
      2'd1:    hist_sel = prev_q;
      2'd2:    hist_sel = pp_q;
      default: hist_sel = e_q;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uw.mul)
      MUL_WPROD: begin
        mul_a = $signed(MUL_A_W'(uw.msel[0] ? er_q : el_q));
        mul_b = $signed(MUL_B_W'(uw.msel[1] ? cr_q : cl_q));
      end
      MUL_TERM: begin
        mul_a = $signed(MUL_A_W'(w_q[uw.msel]));
        mul_b = MUL_B_W'($signed(ram_rdata));
      end
      MUL_GAIN: begin
        mul_a = MUL_A_W'(gain_q[uw.msel]);
        mul_b = MUL_B_W'(hist_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding of the accumulator
  assign corr_rnd = acc_q + CORR_HALF;
  assign corr     = corr_rnd[ACC_W-1:2*FRAC_BITS];
  assign gsum     = GSUM_W'(base_q[uw.gsel]) + GSUM_W'(corr);
  assign gain_new = sat_gain(gsum);
  assign inc_rnd  = acc_q + INC_HALF;
  assign inc_new  = inc_rnd[ACC_W-1:FRAC_BITS];

  assign loc_e    = locate(e_q);
  assign loc_c    = locate(ec_q);
  assign span_ok  = espan_q && loc_c.in_span;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign do_out   = (uw.op == OP_OUT) && out_free;

  // next step
  always_comb begin
    pc_d = pc_q + PC_W'(1);
    unique case (uw.jmp)
      J_NEXT:    pc_d = pc_q + PC_W'(1);
      J_WAIT_IN: pc_d = sample_acc ? pc_q + PC_W'(1) : pc_q;
      J_NOSPAN:  pc_d = span_ok ? pc_q + PC_W'(1) : uw.target;
      J_GOTO:    pc_d = uw.target;
      J_OUT:     pc_d = out_free ? uw.target : pc_q;
      default:   pc_d = PC_IDLE;
    endcase
  end

  // operations of the current step
  always_comb begin
    e_d       = e_q;
    ec_d      = ec_q;
    prev_d    = prev_q;
    pp_d      = pp_q;
    ie_d      = ie_q;
    ic_d      = ic_q;
    el_d      = el_q;
    er_d      = er_q;
    cl_d      = cl_q;
    cr_d      = cr_q;
    espan_d   = espan_q;
    inc_d     = inc_q;
    out_inc_d = out_inc_q;
    drive_d   = drive_q;
    unique case (uw.op)
      OP_ERR: begin
        e_d = sat_dw({meas_q[DATA_W-1], meas_q} - {target_q[DATA_W-1], target_q});
      end
      OP_EC: begin
        ec_d    = sat_dw({e_q[DATA_W-1], e_q} - {prev_q[DATA_W-1], prev_q});
        ie_d    = loc_e.idx;
        el_d    = loc_e.wl;
        er_d    = loc_e.wr;
        espan_d = loc_e.in_span;
      end
      OP_LOCC: begin
        ic_d = loc_c.idx;
        cl_d = loc_c.wl;
        cr_d = loc_c.wr;
      end
      OP_INC: begin
        inc_d = OUT_W'(inc_new);
      end
      OP_OUT: begin
        if (out_free) begin
          drive_d   = sat_out({drive_q[OUT_W-1], drive_q} + {inc_q[OUT_W-1], inc_q});
          out_inc_d = inc_q;
          pp_d      = prev_q;
          prev_d    = e_q;
        end
      end
      default: begin
        e_d = e_q;
      end
    endcase
  end

  assign out_valid_d = do_out || (out_valid_q && !m_axis_tready_i);

  // control state and reset-defined history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      pp_q        <= '0;
      drive_q     <= '0;
      base_q[0]   <= BASE_KP_RST;
      base_q[1]   <= BASE_KI_RST;
      base_q[2]   <= BASE_KD_RST;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      pp_q        <= pp_d;
      drive_q     <= drive_d;
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BASE_KP: base_q[0] <= pwdata[DATA_W-1:0];
          REG_BASE_KI: base_q[1] <= pwdata[DATA_W-1:0];
          REG_BASE_KD: base_q[2] <= pwdata[DATA_W-1:0];
          default:     base_q[0] <= base_q[0];
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      target_q <= in_target;
      meas_q   <= in_measured;
    end
    e_q       <= e_d;
    ec_q      <= ec_d;
    ie_q      <= ie_d;
    ic_q      <= ic_d;
    el_q      <= el_d;
    er_q      <= er_d;
    cl_q      <= cl_d;
    cr_q      <= cr_d;
    espan_q   <= espan_d;
    inc_q     <= inc_d;
    out_inc_q <= out_inc_d;
    if (uw.mul == MUL_WPROD) begin
      w_q[uw.msel] <= mul_p[WPROD_W-1:0];
    end
    if ((uw.mul == MUL_TERM) || (uw.mul == MUL_GAIN)) begin
      prod_q <= mul_p[ACC_W-1:0];
    end
    case (uw.acc)
      ACC_LOAD: acc_q <= prod_q;
      ACC_ADD:  acc_q <= acc_q + prod_q;
      default:  acc_q <= acc_q;
    endcase
    if (uw.op == OP_GAIN) begin
      gain_q[uw.gsel] <= gain_new;
    end
    if (uw.op == OP_GBASE) begin
      gain_q[0] <= base_q[0];
      gain_q[1] <= base_q[1];
      gain_q[2] <= base_q[2];
    end
  end

  // result channel
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_inc_q, drive_q};

  // configuration read-back
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE_KP: prdata = CFG_DATA_W'(base_q[0]);
      REG_BASE_KI: prdata = CFG_DATA_W'(base_q[1]);
      REG_BASE_KD: prdata = CFG_DATA_W'(base_q[2]);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fgpid_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module fgpid_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 147
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
